/* hw/rtl/ptm_pkg.sv */
// Package token matcher: shared constants, token table and types.
`default_nettype none
package ptm_pkg;

  localparam int TOKEN_COUNT  = 38;
  localparam int WINDOW_DEPTH = 8;
  localparam int TOKEN_MAX    = 9;

  localparam int CHAR_W   = 8;
  localparam int HEIGHT_W = 14;
  localparam int MASS_W   = 23;
  localparam int INDEX_W  = 6;
  localparam int LEN_W    = $clog2(TOKEN_MAX + 1);
  localparam int SEEN_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_HEIGHT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MASS   = 1'd1;

  localparam logic [HEIGHT_W-1:0] DEFAULT_HEIGHT_RESET = 14'd1000;
  localparam logic [MASS_W-1:0]   DEFAULT_MASS_RESET   = 23'd100000;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'd32;

  localparam logic [INDEX_W-1:0] NO_MATCH = INDEX_W'(TOKEN_COUNT);

  typedef logic [WINDOW_DEPTH-1:0][CHAR_W-1:0] window_t;
  typedef logic [TOKEN_COUNT-1:0]              hits_t;
  typedef logic [TOKEN_MAX*CHAR_W-1:0]         token_text_t;

  // last character sits in the low byte
  localparam token_text_t TOKEN_TEXT [TOKEN_COUNT] = '{
    "0201", "0402", "0603", "0805", "1206", "1210", "1812", "2010", "2512",
    "sot-23", "sot23", "sot-223", "sot-89", "sot-323", "sot-89",
    "dpak", "d2pak", "to-263", "to-252", "tssop", "msop", "ssop", "soic",
    "qfn", "dfn", "lqfp", "tqfp", "qfp", "bga", "dip",
    "to-220", "to-247", "to-92", "pinheader", "connector", "usb",
    "crystal", "inductor"
  };

  localparam logic [LEN_W-1:0] TOKEN_LEN [TOKEN_COUNT] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd6, 4'd5, 4'd7, 4'd6, 4'd7, 4'd6,
    4'd4, 4'd5, 4'd6, 4'd6, 4'd5, 4'd4, 4'd4, 4'd4,
    4'd3, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd3,
    4'd6, 4'd6, 4'd5, 4'd9, 4'd9, 4'd3,
    4'd7, 4'd8
  };

  localparam logic [HEIGHT_W-1:0] TOKEN_HEIGHT [TOKEN_COUNT] = '{
    14'd300, 14'd450, 14'd550, 14'd700, 14'd1000, 14'd1100, 14'd1500,
    14'd1500, 14'd1800,
    14'd1100, 14'd1100, 14'd1600, 14'd1500, 14'd900, 14'd1500,
    14'd2300, 14'd4400, 14'd4400, 14'd2300, 14'd1100, 14'd1100, 14'd1750,
    14'd1750,
    14'd850, 14'd850, 14'd1400, 14'd1000, 14'd2500, 14'd1200, 14'd4000,
    14'd4500, 14'd5000, 14'd5200, 14'd8500, 14'd8000, 14'd7000,
    14'd4000, 14'd2500
  };

  localparam logic [MASS_W-1:0] TOKEN_MASS [TOKEN_COUNT] = '{
    23'd50, 23'd100, 23'd200, 23'd500, 23'd1000, 23'd1500, 23'd3000,
    23'd4000, 23'd6000,
    23'd8000, 23'd8000, 23'd60000, 23'd40000, 23'd4000, 23'd40000,
    23'd600000, 23'd1600000, 23'd1500000, 23'd600000, 23'd100000,
    23'd50000, 23'd200000, 23'd300000,
    23'd100000, 23'd80000, 23'd500000, 23'd400000, 23'd1000000,
    23'd500000, 23'd1000000,
    23'd2000000, 23'd6000000, 23'd200000, 23'd1000000, 23'd4000000,
    23'd3000000,
    23'd300000, 23'd300000
  };

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = c + CASE_OFFSET;
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ptm_hit_unit.sv */
// Package token matcher: parallel compare of all tokens against byte plus window.
`default_nettype none
module ptm_hit_unit (
  input  wire logic [ptm_pkg::CHAR_W-1:0] cur_char,
  input  wire ptm_pkg::window_t           window,
  input  wire logic [ptm_pkg::SEEN_W-1:0] seen,
  output ptm_pkg::hits_t                  hits
);
  import ptm_pkg::*;

  always_comb begin
    logic                  ok;
    logic [LEN_W-1:0]      need;
    logic [CHAR_W-1:0]     tok_byte;
    for (int i = 0; i < TOKEN_COUNT; i++) begin
      need = TOKEN_LEN[i] - LEN_W'(1);
      ok = (TOKEN_LEN[i] != '0) &&
           (SEEN_W'(need) <= seen) &&
           (int'(need) <= WINDOW_DEPTH);
      for (int k = 0; k < TOKEN_MAX; k++) begin
        tok_byte = TOKEN_TEXT[i][k*CHAR_W +: CHAR_W];
        if (k < int'(TOKEN_LEN[i])) begin
          if (k == 0) begin
            ok = ok && (tok_byte == cur_char);
          end else if (k <= WINDOW_DEPTH) begin
            ok = ok && (tok_byte == window[k-1]);
          end
        end
      end
      hits[i] = ok;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/package_token_matcher.sv */
// Package token matcher top level: byte stream in, one result per name out.
// Path: a final byte enters the input register on acceptance, and its result
//   enters the result register when that byte leaves the input register.
// Throughput: one byte per cycle; a final byte waits in the input register
//   only while the result register holds an undrained beat.
// Reset: synchronous rst clears window, hit flags and valids, and loads the
//   default height and mass registers with their reset values.
`default_nettype none
module package_token_matcher (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_write_en,
  input  wire logic [ptm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ptm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [ptm_pkg::CHAR_W-1:0]         name_char,
  input  wire logic                               last_char,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [ptm_pkg::INDEX_W-1:0]             match_index,
  output logic                                    found,
  output logic [ptm_pkg::HEIGHT_W-1:0]            height_um,
  output logic [ptm_pkg::MASS_W-1:0]              mass_ug
);
  import ptm_pkg::*;

  logic                  s1_valid;
  logic [CHAR_W-1:0]     s1_char;
  logic                  s1_last;
  window_t               window;
  logic [SEEN_W-1:0]     seen;
  hits_t                 hits;
  logic [HEIGHT_W-1:0]   default_height_um;
  logic [MASS_W-1:0]     default_mass_ug;

  hits_t                 new_hits;
  hits_t                 hits_next;
  logic                  slot_free;
  logic                  s1_go;
  logic [INDEX_W-1:0]    sel_index;
  logic                  sel_found;
  logic [HEIGHT_W-1:0]   sel_height;
  logic [MASS_W-1:0]     sel_mass;

  assign slot_free = !out_valid || out_ready;
  assign s1_go     = s1_valid && (!s1_last || slot_free);
  assign in_ready  = !s1_valid || s1_go;

  ptm_hit_unit u_hit (
    .cur_char (s1_char),
    .window   (window),
    .seen     (seen),
    .hits     (new_hits)
  );

  assign hits_next = hits | new_hits;

  always_comb begin
    sel_index  = NO_MATCH;
    sel_found  = 1'b0;
    sel_height = default_height_um;
    sel_mass   = default_mass_ug;
    for (int i = TOKEN_COUNT - 1; i >= 0; i--) begin
      if (hits_next[i]) begin
        sel_index  = INDEX_W'(i);
        sel_found  = 1'b1;
        sel_height = TOKEN_HEIGHT[i];
        sel_mass   = TOKEN_MASS[i];
      end
    end
  end

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      default_height_um <= DEFAULT_HEIGHT_RESET;
      default_mass_ug   <= DEFAULT_MASS_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_DEFAULT_HEIGHT: default_height_um <= cfg_data[HEIGHT_W-1:0];
        REG_DEFAULT_MASS:   default_mass_ug   <= cfg_data[MASS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char <= fold_case(name_char);
      s1_last <= last_char;
    end
  end

  // window and hit flags
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      seen   <= '0;
      hits   <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        window <= '0;
        seen   <= '0;
        hits   <= '0;
      end else begin
        window <= {window[WINDOW_DEPTH-2:0], s1_char};
        if (seen < SEEN_W'(WINDOW_DEPTH)) seen <= seen + SEEN_W'(1);
        hits <= hits_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      match_index <= sel_index;
      found       <= sel_found;
      height_um   <= sel_height;
      mass_ug     <= sel_mass;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ptm_checker.sv */
// Package token matcher: port-level checker and its bind to the top level.
`default_nettype none
module ptm_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ptm_pkg::INDEX_W-1:0]    match_index,
  input wire logic                           found,
  input wire logic [ptm_pkg::HEIGHT_W-1:0]   height_um,
  input wire logic [ptm_pkg::MASS_W-1:0]     mass_ug
);
  import ptm_pkg::*;

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(match_index) &&
      $stable(found) && $stable(height_um) && $stable(mass_ug))
    else $error("result beat changed while stalled");

  a_index_found: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found && match_index < NO_MATCH) ||
                  (!found && match_index == NO_MATCH))
    else $error("match_index disagrees with found");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_first_token: assert property (@(posedge clk) disable iff (rst)
    out_valid && found && match_index == '0 |->
      height_um == TOKEN_HEIGHT[0] && mass_ug == TOKEN_MASS[0])
    else $error("token data does not follow its index");

  a_quiet_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind package_token_matcher ptm_checker u_ptm_checker (.*);
`default_nettype wire
